// ----- hdl/tcaof_pkg.sv -----
// Shared types, constants and codes for the two-class age-ordered FIFO.
package tcaof_pkg;

   // Sizing
   localparam int QUEUE_DEPTH  = 16;
   localparam int HANDLE_BITS  = 16;
   localparam int STAMP_BITS   = 32;
   localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS     = CNT_BITS + 1;
   // The low KEEP_HANDLE_BITS bits of the 16-bit handle field are kept (all 16 here)
   localparam int KEEP_HANDLE_BITS = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

   // Opcodes
   localparam logic [1:0] OP_ENQUEUE    = 2'd0;
   localparam logic [1:0] OP_DEQ_KIND   = 2'd1;
   localparam logic [1:0] OP_DEQ_OLDEST = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;

   // Item classes
   localparam logic KIND_FIRST  = 1'b0;
   localparam logic KIND_SECOND = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        kind;
      logic [15:0] handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        got_item;
      logic        out_kind;
      logic [15:0] out_handle;
      logic [31:0] out_stamp;
   } rsp_type;

   // Command into one class queue
   typedef struct packed {
      logic                        push;
      logic                        pop;
      logic [KEEP_HANDLE_BITS-1:0] handle;
      logic [STAMP_BITS-1:0]       stamp;
   } q_cmd_type;

   // Status out of one class queue
   typedef struct packed {
      logic                        empty;
      logic                        full;
      logic [KEEP_HANDLE_BITS-1:0] head_handle;
      logic [STAMP_BITS-1:0]       head_stamp;
   } q_stat_type;

endpackage

// ----- hdl/tcaof_queue.sv -----
// Circular FIFO for one item class: entry store, head pointer and occupancy.
module tcaof_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  tcaof_pkg::q_cmd_type  cmd,
   output tcaof_pkg::q_stat_type stat
);
   import tcaof_pkg::*;

   logic [KEEP_HANDLE_BITS-1:0] entry_handle_ff [QUEUE_DEPTH];
   logic [STAMP_BITS-1:0]       entry_stamp_ff  [QUEUE_DEPTH];
   logic [KEEP_HANDLE_BITS-1:0] head_handle_ff;
   logic [STAMP_BITS-1:0]       head_stamp_ff;
   logic [PTR_BITS-1:0]         head_ff, head_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic [SUM_BITS-1:0]         tail_sum, tail_wrap, head_sum;
   logic [PTR_BITS-1:0]         tail_idx;

   // Tail index: head + count, wrapped once
   always_comb begin
      tail_sum = SUM_BITS'(head_ff) + SUM_BITS'(count_ff);
      if (tail_sum >= SUM_BITS'(QUEUE_DEPTH)) begin
         tail_wrap = tail_sum - SUM_BITS'(QUEUE_DEPTH);
      end else begin
         tail_wrap = tail_sum;
      end
      tail_idx = tail_wrap[PTR_BITS-1:0];
   end

   // Head and occupancy update
   always_comb begin
      head_sum = SUM_BITS'(head_ff) + SUM_BITS'(1);
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.pop) begin
         head_in = (head_sum >= SUM_BITS'(QUEUE_DEPTH)) ? '0 : head_sum[PTR_BITS-1:0];
      end
      if (cmd.push && !cmd.pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.pop && !cmd.push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Entry store: written at the tail, no reset
   // Head entry register: loaded by a push into an empty queue, or read
   // ahead from the new head position on a pop
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         entry_handle_ff[tail_idx] <= cmd.handle;
         entry_stamp_ff[tail_idx]  <= cmd.stamp;
      end
      if (cmd.push && (count_ff == '0)) begin
         head_handle_ff <= cmd.handle;
         head_stamp_ff  <= cmd.stamp;
      end else if (cmd.pop) begin
         head_handle_ff <= entry_handle_ff[head_in];
         head_stamp_ff  <= entry_stamp_ff[head_in];
      end
   end

   // Status towards the dispatcher
   assign stat.empty       = (count_ff == '0);
   assign stat.full        = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign stat.head_handle = head_handle_ff;
   assign stat.head_stamp  = head_stamp_ff;

endmodule

// ----- hdl/two_class_age_ordered_fifo_core.sv -----
// Top level: two class queues behind a shared arrival stamp counter.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_payload (opcode, kind, handle)
//   rsp      out        rsp_valid / rsp_ready  rsp_payload (status, got_item,
//                                              out_kind, out_handle, out_stamp)
//
// A transaction is captured in an input register, served against the queue
// heads from there and written to the result register; one transaction per cycle
// is sustained while the result register is not stalled.
// Reset empties both queues and clears the stamp counter; entries are not cleared.
// A stalled result holds the input register; req_ready stays high while the
// result register drains in the same cycle.
module two_class_age_ordered_fifo_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcaof_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcaof_pkg::rsp_type rsp_payload
);
   import tcaof_pkg::*;

   req_type               req_ff;
   logic                  req_valid_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic [STAMP_BITS-1:0] arrival_ff, arrival_in, arrival_next;
   logic                  advance;
   q_cmd_type             cmd_first, cmd_second;
   q_stat_type            stat_first, stat_second, stat_take;
   logic [STAMP_BITS-1:0] age_diff;
   logic                  take, any, push, pop;

   // Handshake: the input register moves on when the result register is free
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         arrival_ff   <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         arrival_ff <= arrival_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Wrap-aware age compare: second head is older when the difference goes negative
   assign age_diff     = stat_second.head_stamp - stat_first.head_stamp;
   assign arrival_next = arrival_ff + STAMP_BITS'(1);
   assign stat_take    = take ? stat_second : stat_first;

   // Dispatch one transaction against the queue heads
   always_comb begin
      rsp_in     = '0;
      push       = 1'b0;
      pop        = 1'b0;
      take       = req_ff.kind;
      any        = 1'b0;
      arrival_in = arrival_ff;
      case (req_ff.opcode)
         OP_ENQUEUE: begin
            rsp_in.out_kind = req_ff.kind;
            if ((req_ff.kind == KIND_SECOND) ? stat_second.full : stat_first.full) begin
               rsp_in.status = ST_DROPPED;
            end else begin
               push             = advance;
               rsp_in.out_stamp = 32'(arrival_next);
               if (advance) begin
                  arrival_in = arrival_next;
               end
            end
         end
         OP_DEQ_KIND, OP_DEQ_OLDEST: begin
            if (req_ff.opcode == OP_DEQ_KIND) begin
               any = (req_ff.kind == KIND_SECOND) ? !stat_second.empty : !stat_first.empty;
            end else begin
               any = !stat_first.empty || !stat_second.empty;
               if (!stat_first.empty && !stat_second.empty) begin
                  take = age_diff[STAMP_BITS-1];
               end else begin
                  take = !stat_second.empty;
               end
            end
            if (any) begin
               pop               = advance;
               rsp_in.got_item   = 1'b1;
               rsp_in.out_kind   = take;
               rsp_in.out_handle = 16'(stat_take.head_handle);
               rsp_in.out_stamp  = 32'(stat_take.head_stamp);
            end else begin
               rsp_in.status = ST_EMPTY;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Queue commands
   always_comb begin
      cmd_first.push   = push && (req_ff.kind == KIND_FIRST);
      cmd_second.push  = push && (req_ff.kind == KIND_SECOND);
      cmd_first.pop    = pop && (take == KIND_FIRST);
      cmd_second.pop   = pop && (take == KIND_SECOND);
      cmd_first.handle  = req_ff.handle[KEEP_HANDLE_BITS-1:0];
      cmd_second.handle = req_ff.handle[KEEP_HANDLE_BITS-1:0];
      cmd_first.stamp   = arrival_next;
      cmd_second.stamp  = arrival_next;
   end

   tcaof_queue u_queue_first (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_first),
      .stat  (stat_first)
   );

   tcaof_queue u_queue_second (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_second),
      .stat  (stat_second)
   );

endmodule
